>>> sv/sorted_priority_queue_top_assert.svh
// assertion macros for the sorted priority queue checker
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/spq_pkg.sv
// shared types and codes for the sorted priority queue
package spq_pkg;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic insert;
      logic remove;
   } spq_ctrl_type;

endpackage

>>> sv/spq_cell.sv
// one slot of the sorted queue: holds a key and tag, shifts with its neighbors
module spq_cell
   import spq_pkg::*;
#(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 16
) (
   input  logic                clock,
   input  spq_ctrl_type        ctrl,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [TAG_BITS-1:0] new_tag,
   input  logic                slot_valid,
   input  logic                prev_ge,
   input  logic [KEY_BITS-1:0] prev_key,
   input  logic [TAG_BITS-1:0] prev_tag,
   input  logic [KEY_BITS-1:0] next_key,
   input  logic [TAG_BITS-1:0] next_tag,
   output logic                ge,
   output logic [KEY_BITS-1:0] key,
   output logic [TAG_BITS-1:0] tag,
   output logic [KEY_BITS-1:0] key_next,
   output logic [TAG_BITS-1:0] tag_next
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   // new entry goes ahead of every stored key that is greater or equal
   assign ge = !slot_valid || (key_ff >= new_key);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctrl.remove) begin
         key_in = next_key;
         tag_in = next_tag;
      end else if (ctrl.insert) begin
         if (prev_ge) begin
            key_in = prev_key;
            tag_in = prev_tag;
         end else if (ge) begin
            key_in = new_key;
            tag_in = new_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key      = key_ff;
   assign tag      = tag_ff;
   assign key_next = key_in;
   assign tag_next = tag_in;

endmodule

>>> sv/sorted_priority_queue_top.sv
// sorted priority queue built as a row of shifting slot cells
//
// input channel req_*: one item per handshake; req_tuser is the mode
// (insert or remove head), req_tdata carries the key and tag of an insert.
// result channel rsp_*: exactly one result item per input item, in order,
// with status in rsp_tuser and removed entry, count and head in rsp_tdata.
// the queue keeps entries in ascending key order, head in slot 0; an insert
// lands ahead of all equal keys, so the newest of equal keys leaves first.
// removal from an empty queue and insert into a full queue leave the state
// alone and report their status code.
// the result is registered and shows in the cycle after acceptance.
// throughput: one item per cycle while results are taken; every cell compares
// its key with the new key in parallel and loads from itself, a neighbor or the input.
// when the receiver stalls, the result register holds and req_tready drops
// until the result is taken.
// reset empties the queue and drops any pending result; slot contents are
// not cleared since only slots below the count are ever read.
module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // event_key, event_tag
   input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // removed_key, removed_tag, entry_count, head_valid, head_key, head_tag
   output logic [((2*KEY_BITS+2*TAG_BITS+$clog2(QUEUE_DEPTH+1)+1+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_BITS = ((2*KEY_BITS + 2*TAG_BITS + CW + 1 + 7) / 8) * 8;

   logic [KEY_BITS-1:0] new_key;
   logic [TAG_BITS-1:0] new_tag;
   logic                accept, full, empty, is_remove;
   spq_ctrl_type        ctrl;
   logic [CW-1:0]       count_ff, count_in;

   logic [QUEUE_DEPTH-1:0] cell_valid, cell_ge;
   logic [KEY_BITS-1:0] cell_key [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_tag [QUEUE_DEPTH];
   logic [KEY_BITS-1:0] cell_key_next [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_tag_next [QUEUE_DEPTH];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   logic [KEY_BITS-1:0] rem_key_ff, rem_key_in, head_key_ff, head_key_in;
   logic [TAG_BITS-1:0] rem_tag_ff, rem_tag_in, head_tag_ff, head_tag_in;
   logic [CW-1:0]       out_count_ff;
   logic                head_valid_ff, head_valid_in;

   assign new_key   = req_tdata[KEY_BITS-1:0];
   assign new_tag   = req_tdata[KEY_BITS +: TAG_BITS];
   assign is_remove = (req_tuser[0] == MODE_REMOVE);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);

   assign ctrl.insert = accept && !is_remove && !full;
   assign ctrl.remove = accept && is_remove && !empty;

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                prev_ge;
      logic [KEY_BITS-1:0] prev_key, next_key;
      logic [TAG_BITS-1:0] prev_tag, next_tag;

      assign cell_valid[i] = (CW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign prev_ge  = 1'b0;
         assign prev_key = new_key;
         assign prev_tag = new_tag;
      end else begin : g_inner
         assign prev_ge  = cell_ge[i-1];
         assign prev_key = cell_key[i-1];
         assign prev_tag = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_key = cell_key[i];
         assign next_tag = cell_tag[i];
      end else begin : g_body
         assign next_key = cell_key[i+1];
         assign next_tag = cell_tag[i+1];
      end

      spq_cell #(
         .KEY_BITS(KEY_BITS),
         .TAG_BITS(TAG_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .new_key   (new_key),
         .new_tag   (new_tag),
         .slot_valid(cell_valid[i]),
         .prev_ge   (prev_ge),
         .prev_key  (prev_key),
         .prev_tag  (prev_tag),
         .next_key  (next_key),
         .next_tag  (next_tag),
         .ge        (cell_ge[i]),
         .key       (cell_key[i]),
         .tag       (cell_tag[i]),
         .key_next  (cell_key_next[i]),
         .tag_next  (cell_tag_next[i])
      );
   end

   always_comb begin
      status_in = STATUS_DONE;
      if (is_remove && empty) begin
         status_in = STATUS_EMPTY;
      end else if (!is_remove && full) begin
         status_in = STATUS_FULL;
      end
      rem_key_in    = ctrl.remove ? cell_key[0] : '0;
      rem_tag_in    = ctrl.remove ? cell_tag[0] : '0;
      head_valid_in = (count_in != '0);
      head_key_in   = head_valid_in ? cell_key_next[0] : '0;
      head_tag_in   = head_valid_in ? cell_tag_next[0] : '0;
      rsp_valid_in  = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         rem_key_ff    <= rem_key_in;
         rem_tag_ff    <= rem_tag_in;
         out_count_ff  <= count_in;
         head_valid_ff <= head_valid_in;
         head_key_ff   <= head_key_in;
         head_tag_ff   <= head_tag_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_BITS'({head_tag_ff, head_key_ff, head_valid_ff, out_count_ff,
                                  rem_tag_ff, rem_key_ff});

endmodule

>>> sv/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
`include "sorted_priority_queue_top_assert.svh"

module spq_checker
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int TAG_BITS    = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] req_tdata,
   input logic [0:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2*KEY_BITS+2*TAG_BITS+$clog2(QUEUE_DEPTH+1)+1+7)/8)*8-1:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);

   localparam int CW        = $clog2(QUEUE_DEPTH + 1);
   localparam int COUNT_LSB = KEY_BITS + TAG_BITS;
   localparam int HV_BIT    = COUNT_LSB + CW;

   logic [CW-1:0] rsp_count;
   logic          rsp_head_valid;
   logic          req_seen;

   assign rsp_count      = rsp_tdata[COUNT_LSB +: CW];
   assign rsp_head_valid = rsp_tdata[HV_BIT];
   assign req_seen       = req_tvalid && req_tready && (req_tuser != 1'b0 || req_tdata != '0);

   // a stalled result must hold
   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result item changed")

   // head valid tracks a nonzero count
   `SPQ_ASSERT_NOW(a_head_valid, clock, reset, rsp_tvalid,
      rsp_head_valid == (rsp_count != '0), "head_valid disagrees with entry_count")

   // empty removal reports an empty queue
   `SPQ_ASSERT_NOW(a_empty_status, clock, reset, rsp_tvalid && rsp_tuser == STATUS_EMPTY,
      rsp_count == '0 && !rsp_head_valid, "empty status with stored entries")

   // full insert reports a full queue
   `SPQ_ASSERT_NOW(a_full_status, clock, reset, rsp_tvalid && rsp_tuser == STATUS_FULL,
      rsp_count == CW'(QUEUE_DEPTH), "full status with free slots")

   // an accepted item always yields a result in the next cycle
   `SPQ_ASSERT_NEXT(a_result_follows, clock, reset, req_seen || (req_tvalid && req_tready),
      rsp_tvalid, "accepted item produced no result")

endmodule

bind sorted_priority_queue_top spq_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH),
   .KEY_BITS   (KEY_BITS),
   .TAG_BITS   (TAG_BITS)
) u_spq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

>>> tb/sorted_priority_queue_top_checker.sv
// checker for the sorted priority queue: shadows the queue and compares every result item
`timescale 1ns / 1ps
module sorted_priority_queue_top_checker
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 32,
   parameter int TAG_BITS    = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   // event_key, event_tag
   input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic [0:0] req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   // removed_key, removed_tag, entry_count, head_valid, head_key, head_tag
   input  logic [((2*KEY_BITS+2*TAG_BITS+$clog2(QUEUE_DEPTH+1)+1+7)/8)*8-1:0] rsp_tdata,
   // status
   input  logic [1:0] rsp_tuser,
   output int fail_count,
   output int pending_count,
   output int checked_count,
   output int empty_count,
   output int full_count
);

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int RTAG_LO    = KEY_BITS;
   localparam int COUNT_LO   = KEY_BITS + TAG_BITS;
   localparam int HVALID_LO  = COUNT_LO + COUNT_BITS;
   localparam int HKEY_LO    = HVALID_LO + 1;
   localparam int HTAG_LO    = HKEY_LO + KEY_BITS;

   typedef struct packed {
      logic [1:0]            status;
      logic [KEY_BITS-1:0]   removed_key;
      logic [TAG_BITS-1:0]   removed_tag;
      logic [COUNT_BITS-1:0] entry_count;
      logic                  head_valid;
      logic [KEY_BITS-1:0]   head_key;
      logic [TAG_BITS-1:0]   head_tag;
   } queue_result_type;

   // shadow copy of the queue, head in entry 0
   logic [KEY_BITS-1:0] shadow_key [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] shadow_tag [QUEUE_DEPTH];
   int                  shadow_count;
   queue_result_type    expected_results [$];

   function automatic queue_result_type apply_queue_op(input logic mode,
                                                       input logic [KEY_BITS-1:0] key,
                                                       input logic [TAG_BITS-1:0] tag);
      queue_result_type res;
      int               pos;
      int               i;
      res = '0;
      res.status = STATUS_DONE;
      if (mode == MODE_REMOVE) begin
         if (shadow_count == 0) begin
            res.status = STATUS_EMPTY;
            empty_count++;
         end else begin
            res.removed_key = shadow_key[0];
            res.removed_tag = shadow_tag[0];
            for (i = 0; i + 1 < shadow_count; i++) begin
               shadow_key[i] = shadow_key[i+1];
               shadow_tag[i] = shadow_tag[i+1];
            end
            shadow_count--;
         end
      end else if (shadow_count >= QUEUE_DEPTH) begin
         res.status = STATUS_FULL;
         full_count++;
      end else begin
         // new entry goes ahead of every equal or larger key
         pos = 0;
         while (pos < shadow_count && shadow_key[pos] < key) pos++;
         for (i = shadow_count; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
         end
         shadow_key[pos] = key;
         shadow_tag[pos] = tag;
         shadow_count++;
      end
      res.entry_count = COUNT_BITS'(shadow_count);
      if (shadow_count != 0) begin
         res.head_valid = 1'b1;
         res.head_key   = shadow_key[0];
         res.head_tag   = shadow_tag[0];
      end
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: %s mismatch on result %0d: expected %h, got %h",
                     $realtime, field, checked_count, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         shadow_count = 0;
         expected_results.delete();
         pending_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: result item with nothing outstanding: status %0d data %h",
                           $realtime, rsp_tuser, rsp_tdata);
               end
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_tuser));
               compare_field("removed_key", 64'(want.removed_key),
                             64'(rsp_tdata[0 +: KEY_BITS]));
               compare_field("removed_tag", 64'(want.removed_tag),
                             64'(rsp_tdata[RTAG_LO +: TAG_BITS]));
               compare_field("entry_count", 64'(want.entry_count),
                             64'(rsp_tdata[COUNT_LO +: COUNT_BITS]));
               compare_field("head_valid", 64'(want.head_valid),
                             64'(rsp_tdata[HVALID_LO]));
               compare_field("head_key", 64'(want.head_key),
                             64'(rsp_tdata[HKEY_LO +: KEY_BITS]));
               compare_field("head_tag", 64'(want.head_tag),
                             64'(rsp_tdata[HTAG_LO +: TAG_BITS]));
               checked_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_queue_op(req_tuser[0], req_tdata[0 +: KEY_BITS],
                                                      req_tdata[KEY_BITS +: TAG_BITS]));
         end
         pending_count = expected_results.size();
      end
   end

endmodule

>>> tb/sorted_priority_queue_top_tb.sv
// testbench top for the sorted priority queue: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module sorted_priority_queue_top_tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int KEY_BITS     = 32;
   localparam int TAG_BITS     = 16;
   localparam int REQ_BITS     = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_BITS     =
      ((2*KEY_BITS + 2*TAG_BITS + $clog2(QUEUE_DEPTH+1) + 1 + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASE_ITEMS  = 100;
   localparam int HOLD_CYCLES  = 80;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [REQ_BITS-1:0] req_tdata  = '0;
   logic [0:0]          req_tuser  = MODE_INSERT;
   logic                rsp_tready = 1'b0;
   wire                 req_tready;
   wire                 rsp_tvalid;
   wire [RSP_BITS-1:0]  rsp_tdata;
   wire [1:0]           rsp_tuser;

   int fail_count;
   int pending_count;
   int checked_count;
   int empty_count;
   int full_count;
   int insert_items;
   int remove_items;
   int results_taken;
   bit quiet = 1'b0;

   always #5 clock = ~clock;

   sorted_priority_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .KEY_BITS   (KEY_BITS),
      .TAG_BITS   (TAG_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   sorted_priority_queue_top_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .KEY_BITS   (KEY_BITS),
      .TAG_BITS   (TAG_BITS)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count),
      .empty_count  (empty_count),
      .full_count   (full_count)
   );

   function automatic int draw_gap();
      if (quiet) return 0;
      return $urandom_range(0, 9);
   endfunction

   // tiny keys give plenty of ties, keys near the top exercise the unsigned compare
   function automatic logic [KEY_BITS-1:0] draw_key();
      case ($urandom_range(0, 3))
         0: return KEY_BITS'($urandom_range(0, 7));
         1: return ~KEY_BITS'($urandom_range(0, 7));
         default: return KEY_BITS'($urandom);
      endcase
   endfunction

   task automatic offer_item(input logic mode, input logic [KEY_BITS-1:0] key,
                             input logic [TAG_BITS-1:0] tag);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_BITS'({tag, key});
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_REMOVE) remove_items++;
      else insert_items++;
      @(negedge clock);
   endtask

   // result side: random stalls, plus two long hold-offs so the block backs up
   initial begin : result_sink
      int gap;
      @(negedge clock iff !reset);
      forever begin
         gap = draw_gap();
         if (results_taken == 300 || results_taken == 1200) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int i;
      int insert_pct;
      insert_pct = 50;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty removal, extreme keys and tags, a tie, then fill past the top
      offer_item(MODE_REMOVE, '1, '1);
      offer_item(MODE_INSERT, '0, '0);
      offer_item(MODE_INSERT, '1, '1);
      offer_item(MODE_INSERT, KEY_BITS'(5), TAG_BITS'(16'haaaa));
      offer_item(MODE_INSERT, KEY_BITS'(5), TAG_BITS'(16'h5555));
      offer_item(MODE_REMOVE, '0, '0);
      offer_item(MODE_REMOVE, KEY_BITS'($urandom), TAG_BITS'($urandom));
      for (i = 0; i < QUEUE_DEPTH - 2; i++) begin
         offer_item(MODE_INSERT, draw_key(), TAG_BITS'($urandom));
      end
      offer_item(MODE_INSERT, {1'b1, {(KEY_BITS-1){1'b0}}}, {1'b1, {(TAG_BITS-1){1'b0}}});
      offer_item(MODE_REMOVE, '0, '0);

      // phases lean toward filling, draining or neither
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
            case ((i / PHASE_ITEMS) % 3)
               0: insert_pct = 80;
               1: insert_pct = 25;
               default: insert_pct = 50;
            endcase
         end
         offer_item(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                    draw_key(), TAG_BITS'($urandom));
      end
      req_tvalid <= 1'b0;

      wait (pending_count == 0);
      repeat (10) @(posedge clock);
      $display("run covered %0d inserts and %0d removals, %0d results checked",
               insert_items, remove_items, checked_count);
      $display("%0d removals from an empty queue, %0d inserts into a full queue",
               empty_count, full_count);
      if (fail_count == 0) begin
         $display("sorted_priority_queue_top_tb: PASS");
      end else begin
         $display("sorted_priority_queue_top_tb: FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("timed out with %0d results outstanding", pending_count);
      $display("sorted_priority_queue_top_tb: FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_top.sv
sv/spq_checker.sv
tb/sorted_priority_queue_top_checker.sv
tb/sorted_priority_queue_top_tb.sv
